### rtl/sma_pkg.sv
// Shared types and constants of the simple moving average block.
`default_nettype none

package sma_pkg;

  // Configuration register file.
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEAD_SKIP  = 1'd1;

  localparam int WINDOW_BITS = 9;
  localparam int LEAD_BITS   = 16;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 9'd5;
  localparam logic [LEAD_BITS-1:0]   LEAD_RESET   = 16'd0;
  localparam logic [LEAD_BITS-1:0]   POSITION_MAX = 16'hFFFF;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_SUB  = 6'b000100,
    ST_ADD  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### rtl/sma_ring.sv
// Sample history memory: one write port, one registered read port.
`default_nettype none

module sma_ring
  import sma_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/sma_alu.sv
// Shared adder/subtractor used for the running sum and the divide steps.
`default_nettype none

module sma_alu
  import sma_pkg::*;
#(
  parameter int WIDTH = 33
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic             sub,
  output      logic [WIDTH-1:0] result,
  output      logic             carry
);

  logic [WIDTH-1:0] b_op;

  // On subtract, carry high means a >= b (no borrow).
  assign b_op = sub ? ~b : b;
  assign {carry, result} = {1'b0, a} + {1'b0, b_op} + {{WIDTH{1'b0}}, sub};

endmodule

`default_nettype wire

### rtl/simple_moving_average.sv
// Simple moving average: top level with sequencer, sum and divide control.
//
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser: s_tdata carries one
// unsigned price sample, s_tuser flags the first sample of a new series. Each
// item gives exactly one result on m_tvalid/m_tready/m_tdata/m_tuser: the
// truncated mean of the last window_len accepted samples, with m_tuser high
// once the lead has been skipped and a full window has been collected.
// Invalid results carry an average of zero.
// An item passes from acceptance through ST_PREP, ST_SUB (once the window is
// full), ST_ADD, ST_DIV and ST_FIN to the output register; a skipped sample
// goes from ST_PREP straight to ST_FIN, and while the window fills ST_ADD goes
// to ST_FIN. s_tready is low meanwhile, so a new item is accepted only once
// the previous one has left ST_FIN. The restoring divider produces one quotient
// bit per cycle on the single shared adder that also updates the running sum.
// The output register holds one finished result; a new item is accepted while
// it waits, and the sequencer holds the next result until the receiver takes
// the previous one.
// Reset (rst, synchronous) clears history and position and loads window_len = 5
// and lead_skip = 0. Writing window_len clears the window history; the user
// must make writes only while the block is idle; the block does not enforce it.
`default_nettype none

module simple_moving_average
  import sma_pkg::*;
#(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Input channel.
  input  wire logic                                 s_tvalid,
  output      logic                                 s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // price_sample
  input  wire logic [0:0]                           s_tuser,  // series_start
  // Output channel.
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  output      logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // average
  output      logic [0:0]                           m_tuser,  // average_valid
  // Configuration write port.
  input  wire logic                                 cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]              cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]             cfg_data
);

  localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int AW         = $clog2(MAX_WINDOW);
  localparam int SUM_BITS   = SAMPLE_BITS + WINDOW_BITS;
  localparam int IW         = ((AW > WINDOW_BITS) ? AW : WINDOW_BITS) + 1;
  localparam int CNT_BITS   = $clog2(SAMPLE_BITS);

  state_t state;

  logic [WINDOW_BITS-1:0] window_len;
  logic [LEAD_BITS-1:0]   lead_skip;

  logic [SUM_BITS-1:0]    running_sum;
  logic [AW-1:0]          write_slot;
  logic [WINDOW_BITS-1:0] filled_count;
  logic [LEAD_BITS-1:0]   series_position;

  logic [SAMPLE_BITS-1:0] sample;
  logic                   skip;
  logic [WINDOW_BITS-1:0] rem;
  logic [SAMPLE_BITS-1:0] quo;
  logic [CNT_BITS-1:0]    bit_cnt;
  logic                   res_valid;

  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_avg;
  logic                   out_flag;

  logic [WINDOW_BITS-1:0] win;
  logic [LEAD_BITS-1:0]   pos_cur;
  logic [IW-1:0]          slot_ext;
  logic [IW-1:0]          win_ext;
  logic [IW-1:0]          old_ext;
  logic [AW-1:0]          old_slot;
  logic [AW-1:0]          slot_inc;
  logic [WINDOW_BITS:0]   shifted;

  logic [SUM_BITS-1:0]    alu_a;
  logic [SUM_BITS-1:0]    alu_b;
  logic                   alu_sub;
  logic [SUM_BITS-1:0]    alu_res;
  logic                   alu_carry;

  logic                   ring_we;
  logic                   ring_re;
  logic [SAMPLE_BITS-1:0] ring_rdata;

  logic                   in_fire;
  logic                   out_free;

  // Effective window: zero acts as one, oversize acts as the ring depth.
  always_comb begin
    if (window_len == '0) begin
      win = WINDOW_BITS'(1);
    end else if (int'(window_len) > MAX_WINDOW) begin
      win = WINDOW_BITS'(MAX_WINDOW);
    end else begin
      win = window_len;
    end
  end

  assign slot_ext = IW'(write_slot);
  assign win_ext  = IW'(win);
  assign old_ext  = (slot_ext >= win_ext) ? (slot_ext - win_ext)
                                          : (slot_ext + IW'(MAX_WINDOW) - win_ext);
  assign old_slot = old_ext[AW-1:0];
  assign slot_inc = (write_slot == AW'(MAX_WINDOW - 1)) ? '0 : write_slot + AW'(1);

  assign pos_cur = s_tuser[0] ? '0 : series_position;
  assign shifted = {rem, quo[SAMPLE_BITS-1]};

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = running_sum;
    alu_b   = SUM_BITS'(sample);
    alu_sub = 1'b0;
    unique case (state)
      ST_SUB: begin
        alu_b   = SUM_BITS'(ring_rdata);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = SUM_BITS'(shifted);
        alu_b   = SUM_BITS'(win);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign ring_we = (state == ST_ADD);
  assign ring_re = (state == ST_PREP);

  sma_alu #(
    .WIDTH (SUM_BITS)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_res),
    .carry  (alu_carry)
  );

  sma_ring #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (sample),
    .re    (ring_re),
    .raddr (old_slot),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      window_len      <= WINDOW_RESET;
      lead_skip       <= LEAD_RESET;
      running_sum     <= '0;
      write_slot      <= '0;
      filled_count    <= '0;
      series_position <= '0;
      res_valid       <= 1'b0;
      skip            <= 1'b0;
      bit_cnt         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LEN: begin
            window_len   <= cfg_data[WINDOW_BITS-1:0];
            running_sum  <= '0;
            write_slot   <= '0;
            filled_count <= '0;
          end
          REG_LEAD_SKIP: begin
            lead_skip <= cfg_data[LEAD_BITS-1:0];
          end
          default: begin
            lead_skip <= lead_skip;
          end
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            sample <= s_tdata[SAMPLE_BITS-1:0];
            skip   <= (pos_cur < lead_skip);
            series_position <= (pos_cur == POSITION_MAX) ? pos_cur
                                                         : pos_cur + LEAD_BITS'(1);
            if (s_tuser[0]) begin
              running_sum  <= '0;
              write_slot   <= '0;
              filled_count <= '0;
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (skip) begin
            res_valid <= 1'b0;
            state     <= ST_FIN;
          end else if (filled_count >= win) begin
            state <= ST_SUB;
          end else begin
            filled_count <= filled_count + WINDOW_BITS'(1);
            state        <= ST_ADD;
          end
        end
        ST_SUB: begin
          running_sum <= alu_res;
          state       <= ST_ADD;
        end
        ST_ADD: begin
          running_sum <= alu_res;
          write_slot  <= slot_inc;
          if (filled_count >= win) begin
            // Quotient fits in SAMPLE_BITS, so the top bits start the remainder.
            rem       <= alu_res[SUM_BITS-1:SAMPLE_BITS];
            quo       <= alu_res[SAMPLE_BITS-1:0];
            bit_cnt   <= CNT_BITS'(SAMPLE_BITS - 1);
            res_valid <= 1'b1;
            state     <= ST_DIV;
          end else begin
            res_valid <= 1'b0;
            state     <= ST_FIN;
          end
        end
        ST_DIV: begin
          rem <= alu_carry ? alu_res[WINDOW_BITS-1:0] : shifted[WINDOW_BITS-1:0];
          quo <= {quo[SAMPLE_BITS-2:0], alu_carry};
          if (bit_cnt == '0) begin
            state <= ST_FIN;
          end else begin
            bit_cnt <= bit_cnt - CNT_BITS'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result loaded in the same cycle as the previous one is taken stays valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_avg  <= res_valid ? quo : '0;
      out_flag <= res_valid;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_BITS'(out_avg);
  assign m_tuser  = out_flag;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= win)
    else $error("fill count exceeds the window length");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    int'(write_slot) < MAX_WINDOW)
    else $error("write slot outside the ring");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("invalid result carries a nonzero average");

endmodule

`default_nettype wire
